// File: src/desd_pkg.sv
// Shared types, constants and the code table for the delta endpoint stream decoder.
// Depends on nothing; used by the parser, the record queue and the accumulator.
package desd_pkg;

    // Field widths
    localparam int BYTE_W       = 8;
    localparam int DELTA_W      = 30;
    localparam int INDEX_W      = 34;
    localparam int ENDPOINT_W   = 64;
    localparam int BASE_W       = 12;
    localparam int EXTRA_W      = 4;
    localparam int HOLD_W       = 9;
    localparam int LEFT_W       = 6;

    // Record layout
    localparam logic [7:0] ESC_CODE             = 8'hff;
    localparam logic [LEFT_W-1:0] LIT_BITS       = 6'd10;
    localparam logic [LEFT_W-1:0] IDX_BITS       = 6'd33;
    localparam logic [LEFT_W-1:0] ESC_DELTA_BITS = 6'd30;
    localparam logic [LEFT_W-1:0] ESC_INDEX_BITS = 6'd34;
    localparam int ENDPOINT_SHIFT                = 12;

    // One decoded record handed from the parser to the accumulator
    typedef struct packed {
        logic               escaped;
        logic [INDEX_W-1:0] index;
        logic [DELTA_W-1:0] delta;
    } record_t;

    // Base and extra-bit count of a non-escape code. Groups of codes are laid
    // out by extra-bit count, each group's base following the previous one.
    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [EXTRA_W-1:0] extra;
    } code_entry_t;

    function automatic code_entry_t code_lookup(input logic [7:0] code);
        code_entry_t        ent;
        logic [7:0]         first;
        logic [BASE_W-1:0]  gbase;
        logic [EXTRA_W-1:0] ext;
        logic [BASE_W-1:0]  offs;
        begin
            priority if (code >= 8'd255)
            begin
                first = 8'd255; gbase = 12'd0;    ext = 4'd0;
            end
            else if (code >= 8'd254)
            begin
                first = 8'd254; gbase = 12'd3568; ext = 4'd9;
            end
            else if (code >= 8'd252)
            begin
                first = 8'd252; gbase = 12'd3056; ext = 4'd8;
            end
            else if (code >= 8'd248)
            begin
                first = 8'd248; gbase = 12'd2544; ext = 4'd7;
            end
            else if (code >= 8'd240)
            begin
                first = 8'd240; gbase = 12'd2032; ext = 4'd6;
            end
            else if (code >= 8'd224)
            begin
                first = 8'd224; gbase = 12'd1520; ext = 4'd5;
            end
            else if (code >= 8'd192)
            begin
                first = 8'd192; gbase = 12'd1008; ext = 4'd4;
            end
            else if (code >= 8'd130)
            begin
                first = 8'd130; gbase = 12'd512;  ext = 4'd3;
            end
            else if (code >= 8'd4)
            begin
                first = 8'd4;   gbase = 12'd8;    ext = 4'd2;
            end
            else
            begin
                first = 8'd0;   gbase = 12'd0;    ext = 4'd1;
            end
            offs      = BASE_W'(code - first) << ext;
            ent.base  = gbase + offs;
            ent.extra = ext;
            return ent;
        end
    endfunction

endpackage

// File: src/desd_front.sv
// Byte parser: takes one compressed byte per cycle, walks its eight bits
// MSB first and emits finished records. Depends on desd_pkg.
module desd_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  logic [7:0]             byte_data,
    output logic                   rec_valid,
    output desd_pkg::record_t      rec
);

    localparam logic [2:0] PH_CODE      = 3'd0;
    localparam logic [2:0] PH_EXTRA     = 3'd1;
    localparam logic [2:0] PH_LIT       = 3'd2;
    localparam logic [2:0] PH_IDX       = 3'd3;
    localparam logic [2:0] PH_ESC_DELTA = 3'd4;
    localparam logic [2:0] PH_ESC_INDEX = 3'd5;

    typedef struct packed {
        logic [2:0]                     phase;
        logic [desd_pkg::LEFT_W-1:0]    left;
        logic [desd_pkg::HOLD_W-1:0]    hold;
        logic [2:0]                     held;
        logic [desd_pkg::DELTA_W-1:0]   delta;
        logic [desd_pkg::INDEX_W-1:0]   index;
        logic                           esc;
    } parse_state_t;

    typedef struct packed {
        parse_state_t st;
        logic         done;
    } step_result_t;

    // Advance the parser by one bit
    function automatic step_result_t step_bit(input parse_state_t cur, input logic b);
        step_result_t           res;
        logic [7:0]             code;
        desd_pkg::code_entry_t  ent;
        logic [desd_pkg::HOLD_W-1:0] hold_new;
        begin
            res.st   = cur;
            res.done = 1'b0;
            code     = {cur.hold[6:0], b};
            ent      = desd_pkg::code_lookup(code);
            hold_new = {cur.hold[desd_pkg::HOLD_W-2:0], b};
            unique case (cur.phase)
                PH_EXTRA:
                begin
                    res.st.hold = hold_new;
                    res.st.left = cur.left - 1'b1;
                    if (cur.left == 6'd1)
                    begin
                        res.st.delta = cur.delta + desd_pkg::DELTA_W'(hold_new);
                        res.st.hold  = '0;
                        res.st.phase = PH_LIT;
                        res.st.left  = desd_pkg::LIT_BITS;
                    end
                end
                PH_LIT:
                begin
                    res.st.delta = {cur.delta[desd_pkg::DELTA_W-2:0], b};
                    res.st.left  = cur.left - 1'b1;
                    if (cur.left == 6'd1)
                    begin
                        res.st.phase = PH_IDX;
                        res.st.left  = desd_pkg::IDX_BITS;
                        res.st.index = '0;
                    end
                end
                PH_ESC_DELTA:
                begin
                    res.st.delta = {cur.delta[desd_pkg::DELTA_W-2:0], b};
                    res.st.left  = cur.left - 1'b1;
                    if (cur.left == 6'd1)
                    begin
                        res.st.phase = PH_ESC_INDEX;
                        res.st.left  = desd_pkg::ESC_INDEX_BITS;
                        res.st.index = '0;
                    end
                end
                PH_IDX, PH_ESC_INDEX:
                begin
                    res.st.index = {cur.index[desd_pkg::INDEX_W-2:0], b};
                    res.st.left  = cur.left - 1'b1;
                    res.done     = (cur.left == 6'd1);
                end
                default:
                begin
                    // Gather code bits; decode once eight have arrived
                    res.st.phase = PH_CODE;
                    res.st.hold  = desd_pkg::HOLD_W'(code);
                    res.st.held  = cur.held + 1'b1;
                    if (cur.held == 3'd7)
                    begin
                        res.st.hold  = '0;
                        res.st.held  = '0;
                        res.st.index = '0;
                        if (code == desd_pkg::ESC_CODE)
                        begin
                            res.st.esc   = 1'b1;
                            res.st.delta = '0;
                            res.st.phase = PH_ESC_DELTA;
                            res.st.left  = desd_pkg::ESC_DELTA_BITS;
                        end
                        else
                        begin
                            res.st.esc   = 1'b0;
                            res.st.delta = desd_pkg::DELTA_W'(ent.base);
                            if (ent.extra != '0)
                            begin
                                res.st.phase = PH_EXTRA;
                                res.st.left  = desd_pkg::LEFT_W'(ent.extra);
                            end
                            else
                            begin
                                res.st.phase = PH_LIT;
                                res.st.left  = desd_pkg::LIT_BITS;
                            end
                        end
                    end
                end
            endcase
            return res;
        end
    endfunction

    parse_state_t state_reg;
    parse_state_t state_next;
    step_result_t steps [8];
    parse_state_t carry [9];

    // Walk the byte MSB first; at most one record can finish per byte
    always_comb
    begin
        carry[0]  = state_reg;
        rec_valid = 1'b0;
        rec       = '0;
        for (int k = 0; k < 8; k++)
        begin
            steps[k]     = step_bit(carry[k], byte_data[7-k]);
            carry[k+1]   = steps[k].st;
            if (steps[k].done)
            begin
                rec_valid     = byte_valid;
                rec.delta     = steps[k].st.delta;
                rec.index     = steps[k].st.index;
                rec.escaped   = steps[k].st.esc;
                carry[k+1].phase = PH_CODE;
                carry[k+1].left  = '0;
                carry[k+1].delta = '0;
                carry[k+1].index = '0;
                carry[k+1].hold  = '0;
                carry[k+1].held  = '0;
            end
        end
        state_next = byte_valid ? carry[8] : state_reg;
    end

    // Hold parser state between bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    // A normal record carries a 33-bit index and a delta below 2^22
    a_normal_record_range: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec.escaped |-> !rec.index[33] && (rec.delta[29:22] == '0))
        else $error("normal record out of range");

    // Parser state only moves when a byte is taken
    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_valid |=> $stable(state_reg))
        else $error("parser state moved without a byte");
`endif

endmodule

// File: src/desd_queue.sv
// Short record queue between the parser and the accumulator.
// Depends on desd_pkg for the record type.
module desd_queue
#(
    parameter int AW = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  desd_pkg::record_t      push_rec,
    output logic                   full,
    input  logic                   pop,
    output logic                   avail,
    output desd_pkg::record_t      head
);

    localparam int DEPTH = 1 << AW;

    desd_pkg::record_t slots [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW:0]       count_reg;
    logic [AW:0]       count_next;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign avail = (count_reg != '0);
    assign head  = slots[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Store records
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_rec;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    // Never write into a full queue nor read an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !avail))
        else $error("record queue overflow or underflow");

    // Occupancy agrees with the pointer distance
    a_count_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[AW-1:0])
        else $error("record queue count out of step with pointers");
`endif

endmodule

// File: src/desd_back.sv
// Accumulator: adds each record's delta, shifted left twelve, to the running
// endpoint and holds the result for the output channel. Depends on desd_pkg.
module desd_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           avail,
    input  desd_pkg::record_t              head,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [desd_pkg::ENDPOINT_W-1:0] endpoint,
    output logic [desd_pkg::INDEX_W-1:0]   chain_index,
    output logic                           was_escaped
);

    logic                            valid_reg;
    logic [desd_pkg::ENDPOINT_W-1:0] endpoint_reg;
    logic [desd_pkg::INDEX_W-1:0]    index_reg;
    logic                            esc_reg;
    logic [desd_pkg::ENDPOINT_W-1:0] step_add;

    // Take a record whenever the output register is free or being drained
    assign pop      = avail && (!valid_reg || out_ready);
    assign step_add = {(desd_pkg::ENDPOINT_W - desd_pkg::DELTA_W - desd_pkg::ENDPOINT_SHIFT)'(0),
                       head.delta, desd_pkg::ENDPOINT_SHIFT'(0)};

    assign out_valid   = valid_reg;
    assign endpoint    = endpoint_reg;
    assign chain_index = index_reg;
    assign was_escaped = esc_reg;

    // Accumulate endpoint and load output payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            endpoint_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg    <= 1'b1;
                endpoint_reg <= endpoint_reg + step_add;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            index_reg <= head.index;
            esc_reg   <= head.escaped;
        end
    end

`ifndef ASSERT_OFF
    // A popped record always shows up on the output next cycle
    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid)
        else $error("popped record not presented");

    // The running endpoint moves only by taking a record
    a_endpoint_moves_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> $stable(endpoint_reg))
        else $error("endpoint changed without a record");
`endif

endmodule

// File: src/delta_endpoint_stream_decoder.sv
// Top level of the delta endpoint stream decoder: parser, record queue and
// accumulator. Depends on desd_pkg, desd_front, desd_queue and desd_back.
//
// Usage:
//   Slave channel carries compressed bytes (s_tdata), consumed MSB first.
//   Master channel carries one decoded record: m_tdata holds the running
//   endpoint and the chain index, m_tuser flags an escaped record.
//   Throughput: one byte per cycle unless stalled. Every byte is parsed in the cycle it is
//   accepted, all eight bits at once, so at most one record ends per byte.
//   A record whose last bit arrives in a byte is written to the queue on the
//   edge that accepts the byte, then enters the output register (accumulate)
//   and shows on m_tvalid once that register is free. The accumulator adds
//   one record per cycle into the 64-bit endpoint unless the output stalls.
//   Reset: the parser waits for a code, the endpoint is zero, the queue and
//   output register are empty.
//   Stall: while m_tready is low the output register holds its record; up to
//   2**QUEUE_AW further records wait in the queue, and once it is full
//   s_tready drops until the output drains.
module delta_endpoint_stream_decoder
#(
    parameter int QUEUE_AW = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] stream_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,    // [63:0] endpoint, [97:64] chain_index, [103:98] zero
    output logic [0:0]   m_tuser     // [0] was_escaped
);

    logic              byte_take;
    logic              rec_valid;
    desd_pkg::record_t rec;
    logic              q_full;
    logic              q_avail;
    logic              q_pop;
    desd_pkg::record_t q_head;
    logic [desd_pkg::ENDPOINT_W-1:0] endpoint;
    logic [desd_pkg::INDEX_W-1:0]    chain_index;
    logic                            was_escaped;

    // Accept a byte whenever the queue can absorb a record
    assign s_tready  = !q_full;
    assign byte_take = s_tvalid && !q_full;

    desd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_take),
        .byte_data  (s_tdata),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    desd_queue #(.AW(QUEUE_AW)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rec_valid),
        .push_rec (rec),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (q_head)
    );

    desd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .avail       (q_avail),
        .head        (q_head),
        .pop         (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .endpoint    (endpoint),
        .chain_index (chain_index),
        .was_escaped (was_escaped)
    );

    // Pack the output channel
    assign m_tdata    = {6'd0, chain_index, endpoint};
    assign m_tuser[0] = was_escaped;

endmodule
